FILE: rtl/cpts_pkg.sv
package cpts_pkg;

   localparam int TASK_SLOTS = 64;

   localparam logic [3:0] FUNC_TICK      = 4'd0;
   localparam logic [3:0] FUNC_SCHEDULE  = 4'd1;
   localparam logic [3:0] FUNC_INSTALL   = 4'd2;
   localparam logic [3:0] FUNC_REMOVE    = 4'd3;
   localparam logic [3:0] FUNC_SET_STATE = 4'd4;
   localparam logic [3:0] FUNC_ALARM     = 4'd5;
   localparam logic [3:0] FUNC_NICE      = 4'd6;
   localparam logic [3:0] FUNC_POST      = 4'd7;
   localparam logic [3:0] FUNC_CLEAR     = 4'd8;

   localparam logic [1:0] RUN_RUNNING  = 2'd0;
   localparam logic [1:0] RUN_INTR     = 2'd1;
   localparam logic [1:0] RUN_UNINTR   = 2'd2;

   localparam logic [31:0] ALARM_BIT   = 32'h0000_2000;
   localparam logic [8:0]  IDLE_SLICE  = 9'd15;
   localparam logic [7:0]  IDLE_PRIO   = 8'd15;
   localparam logic [7:0]  PRIO_MAX    = 8'd255;
   localparam logic [9:0]  TPS_RESET   = 10'd100;

   typedef struct packed {
      logic [1:0]  run_state;
      logic [8:0]  slice;
      logic [7:0]  prio;
      logic [31:0] alarm;
      logic [31:0] pending;
      logic [31:0] uticks;
      logic [31:0] sticks;
   } task_row_type;

   typedef enum logic [1:0] {
      SCAN_ALARM,
      SCAN_SELECT,
      SCAN_RECHARGE
   } scan_kind_type;

   typedef struct packed {
      logic          req_load;
      logic          op_rd;
      logic          op_exec;
      logic          scan_start;
      logic          sel_clear;
      scan_kind_type scan_kind;
      logic          set_running;
      logic          rsp_load;
   } cpts_cmd_type;

   typedef struct packed {
      logic need_sched;
      logic last_done;
      logic found;
      logic best_zero;
   } cpts_status_type;

endpackage

FILE: rtl/counter_priority_task_scheduler.sv
// Task scheduler with a table of TASK_SLOTS entries kept in one memory row per
// task, with one read and one write port. Every item returns exactly one
// result. An item that does not schedule reads its row, executes and then loads
// its result. An item that schedules walks the table one entry per cycle: an
// alarm and wake pass and a selection pass; when every runnable slice is
// spent, a recharge pass and a second selection follow.
// A new item is taken once the previous one has finished, even while its
// result still waits to be taken.
module counter_priority_task_scheduler (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [3:0]        req_func,
   input  logic [5:0]        req_task_index,
   input  logic              req_user_mode,
   input  logic [1:0]        req_new_state,
   input  logic [7:0]        req_priority_value,
   input  logic [8:0]        req_counter_value,
   input  logic [15:0]       req_alarm_seconds,
   input  logic signed [8:0] req_nice_increment,
   input  logic [5:0]        req_signal_number,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_accepted,
   output logic              rsp_switched,
   output logic [5:0]        rsp_current_task,
   output logic [8:0]        rsp_current_counter,
   input  logic              csr_write_enable,
   input  logic [9:0]        csr_write_data
);
   import cpts_pkg::*;

   cpts_cmd_type    cmd;
   cpts_status_type sts;

   cpts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cpts_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_func            (req_func),
      .req_task_index      (req_task_index),
      .req_user_mode       (req_user_mode),
      .req_new_state       (req_new_state),
      .req_priority_value  (req_priority_value),
      .req_counter_value   (req_counter_value),
      .req_alarm_seconds   (req_alarm_seconds),
      .req_nice_increment  (req_nice_increment),
      .req_signal_number   (req_signal_number),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_accepted        (rsp_accepted),
      .rsp_switched        (rsp_switched),
      .rsp_current_task    (rsp_current_task),
      .rsp_current_counter (rsp_current_counter)
   );

endmodule

FILE: rtl/cpts_ctrl.sv
module cpts_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  cpts_pkg::cpts_status_type sts,
   output cpts_pkg::cpts_cmd_type   cmd
);
   import cpts_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OP_RD,
      ST_OP_EX,
      ST_AW,
      ST_SEL,
      ST_SEL_CHK,
      ST_RCH,
      ST_FIN,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      pass_ff, pass_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.scan_kind = SCAN_ALARM;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = ST_OP_RD;
            end
         end
         ST_OP_RD: begin
            cmd.op_rd = 1'b1;
            state_in  = ST_OP_EX;
         end
         ST_OP_EX: begin
            cmd.op_exec = 1'b1;
            pass_in     = 1'b0;
            if (sts.need_sched) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_AW;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_AW: begin
            cmd.scan_kind = SCAN_ALARM;
            if (sts.last_done) begin
               cmd.scan_start = 1'b1;
               cmd.sel_clear  = 1'b1;
               state_in       = ST_SEL;
            end
         end
         ST_SEL: begin
            cmd.scan_kind = SCAN_SELECT;
            if (sts.last_done) begin
               state_in = ST_SEL_CHK;
            end
         end
         ST_SEL_CHK: begin
            if (!sts.found || !sts.best_zero) begin
               cmd.set_running = 1'b1;
               state_in        = ST_FIN;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_RCH;
            end
         end
         ST_RCH: begin
            cmd.scan_kind = SCAN_RECHARGE;
            if (sts.last_done) begin
               if (!pass_ff) begin
                  // All runnable slices were spent: select once more.
                  pass_in        = 1'b1;
                  cmd.scan_start = 1'b1;
                  cmd.sel_clear  = 1'b1;
                  state_in       = ST_SEL;
               end else begin
                  cmd.set_running = 1'b1;
                  state_in        = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_scan_ends_in_scan_state: assert property (@(posedge clock) disable iff (reset)
      sts.last_done |-> (state_ff == ST_AW || state_ff == ST_SEL || state_ff == ST_RCH))
      else $error("scan finished outside a scan state");
   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");
   a_exec_follows_read: assert property (@(posedge clock) disable iff (reset)
      cmd.op_rd |=> cmd.op_exec)
      else $error("operation read not followed by execution");
`endif

endmodule

FILE: rtl/cpts_dpath.sv
module cpts_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  cpts_pkg::cpts_cmd_type    cmd,
   output cpts_pkg::cpts_status_type sts,
   input  logic [3:0]                req_func,
   input  logic [5:0]                req_task_index,
   input  logic                      req_user_mode,
   input  logic [1:0]                req_new_state,
   input  logic [7:0]                req_priority_value,
   input  logic [8:0]                req_counter_value,
   input  logic [15:0]               req_alarm_seconds,
   input  logic signed [8:0]         req_nice_increment,
   input  logic [5:0]                req_signal_number,
   input  logic                      csr_write_enable,
   input  logic [9:0]                csr_write_data,
   output logic                      rsp_accepted,
   output logic                      rsp_switched,
   output logic [5:0]                rsp_current_task,
   output logic [8:0]                rsp_current_counter
);
   import cpts_pkg::*;

   localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(TASK_SLOTS - 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(1);

   // Item fields held for the whole operation.
   logic [3:0]        func_ff;
   logic [5:0]        idx_ff;
   logic              umode_ff;
   logic [1:0]        nstate_ff;
   logic [7:0]        prio_ff;
   logic [8:0]        cnt_ff;
   logic [15:0]       secs_ff;
   logic signed [8:0] incr_ff;
   logic [5:0]        sig_ff;

   logic [9:0]        tps_ff;
   logic [25:0]       prod_ff;
   logic [31:0]       jiffy_ff;
   logic [IDX_W-1:0]  running_ff;

   task_row_type      mem [TASK_SLOTS];
   task_row_type      rd_data_ff;
   logic [IDX_W-1:0]  rd_addr_ff;
   logic              rd_valid_ff;
   logic              valid_ff   [TASK_SLOTS];
   logic              written_ff [TASK_SLOTS];

   logic [IDX_W-1:0]  scan_cnt_ff;
   logic              scan_on_ff;

   logic              found_ff;
   logic [8:0]        best_ff;
   logic [IDX_W-1:0]  pick_ff;

   logic              acc_ff, sw_ff;

   logic [IDX_W-1:0]  idx_addr;
   logic              idx_ok;
   logic              uses_idx;
   logic [IDX_W-1:0]  rd_addr;
   task_row_type      row_eff;
   logic              valid_a;

   task_row_type      op_row, scan_row, wr_data;
   logic              op_acc, op_sched, op_wr, op_set_valid, op_clr_valid;
   logic              scan_wr;
   logic              wr_en;
   logic              sel_take;
   logic signed [9:0] nice_r;
   logic [8:0]        half_sum;

   assign idx_addr = IDX_W'(idx_ff);
   assign idx_ok   = 32'(idx_ff) < TASK_SLOTS;
   assign uses_idx = func_ff inside {FUNC_INSTALL, FUNC_REMOVE, FUNC_SET_STATE,
                                     FUNC_POST, FUNC_CLEAR};

   always_comb begin
      if (scan_on_ff) begin
         rd_addr = scan_cnt_ff;
      end else if (cmd.op_rd && uses_idx) begin
         rd_addr = idx_addr;
      end else begin
         rd_addr = running_ff;
      end
   end

   // An entry never written still holds its reset contents.
   always_comb begin
      row_eff = rd_data_ff;
      if (!written_ff[rd_addr_ff]) begin
         row_eff = '0;
         if (rd_addr_ff == '0) begin
            row_eff.slice = IDLE_SLICE;
            row_eff.prio  = IDLE_PRIO;
         end
      end
   end

   assign valid_a = valid_ff[rd_addr_ff];
   assign nice_r  = $signed({2'b00, row_eff.prio}) - $signed({incr_ff[8], incr_ff});

   always_comb begin
      op_row       = row_eff;
      op_acc       = 1'b0;
      op_sched     = 1'b0;
      op_wr        = 1'b0;
      op_set_valid = 1'b0;
      op_clr_valid = 1'b0;
      case (func_ff)
         FUNC_TICK: begin
            op_acc = 1'b1;
            op_wr  = 1'b1;
            if (umode_ff) begin
               op_row.uticks = row_eff.uticks + 32'd1;
            end else begin
               op_row.sticks = row_eff.sticks + 32'd1;
            end
            if (row_eff.slice > 9'd1) begin
               op_row.slice = row_eff.slice - 9'd1;
            end else begin
               op_row.slice = '0;
               op_sched     = umode_ff;
            end
         end
         FUNC_SCHEDULE: begin
            op_acc   = 1'b1;
            op_sched = 1'b1;
         end
         FUNC_INSTALL: begin
            if (idx_ok && idx_addr != '0 && !valid_a && prio_ff != '0) begin
               op_acc       = 1'b1;
               op_wr        = 1'b1;
               op_set_valid = 1'b1;
               op_row       = '0;
               op_row.slice = cnt_ff;
               op_row.prio  = prio_ff;
            end
         end
         FUNC_REMOVE: begin
            if (idx_ok && idx_addr != '0 && valid_a) begin
               op_acc       = 1'b1;
               op_wr        = 1'b1;
               op_clr_valid = 1'b1;
               op_row       = '0;
               op_sched     = (idx_addr == running_ff);
            end
         end
         FUNC_SET_STATE: begin
            if (idx_ok && idx_addr != '0 && valid_a &&
                (nstate_ff inside {RUN_RUNNING, RUN_INTR, RUN_UNINTR})) begin
               op_acc           = 1'b1;
               op_wr            = 1'b1;
               op_row.run_state = nstate_ff;
               op_sched         = (idx_addr == running_ff) && (nstate_ff != RUN_RUNNING);
            end
         end
         FUNC_ALARM: begin
            op_acc       = 1'b1;
            op_wr        = 1'b1;
            op_row.alarm = (secs_ff != '0) ? (jiffy_ff + 32'(prod_ff)) : '0;
         end
         FUNC_NICE: begin
            if (!nice_r[9] && nice_r != '0) begin
               op_acc      = 1'b1;
               op_wr       = 1'b1;
               op_row.prio = nice_r[8] ? PRIO_MAX : nice_r[7:0];
            end
         end
         FUNC_POST: begin
            if (idx_ok && valid_a && sig_ff >= 6'd1 && sig_ff <= 6'd32) begin
               op_acc         = 1'b1;
               op_wr          = 1'b1;
               op_row.pending = row_eff.pending | (32'd1 << 5'(sig_ff - 6'd1));
            end
         end
         FUNC_CLEAR: begin
            if (idx_ok && valid_a) begin
               op_acc         = 1'b1;
               op_wr          = 1'b1;
               op_row.pending = '0;
            end
         end
         default: begin
            op_acc = 1'b0;
         end
      endcase
   end

   assign half_sum = {1'b0, row_eff.slice[8:1]} + {1'b0, row_eff.prio};

   always_comb begin
      scan_row = row_eff;
      scan_wr  = 1'b0;
      sel_take = 1'b0;
      if (rd_valid_ff && valid_a) begin
         case (cmd.scan_kind)
            SCAN_ALARM: begin
               scan_wr = 1'b1;
               if (row_eff.alarm != '0 && row_eff.alarm < jiffy_ff) begin
                  scan_row.pending = row_eff.pending | ALARM_BIT;
                  scan_row.alarm   = '0;
               end
               if (scan_row.pending != '0 && row_eff.run_state == RUN_INTR) begin
                  scan_row.run_state = RUN_RUNNING;
               end
            end
            SCAN_SELECT: begin
               sel_take = (row_eff.run_state == RUN_RUNNING) &&
                          (!found_ff || row_eff.slice > best_ff);
            end
            SCAN_RECHARGE: begin
               scan_wr        = 1'b1;
               scan_row.slice = half_sum;
            end
            default: begin
               scan_wr = 1'b0;
            end
         endcase
      end
   end

   assign wr_en   = (cmd.op_exec && op_wr) || scan_wr;
   assign wr_data = cmd.op_exec ? op_row : scan_row;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[rd_addr_ff] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TASK_SLOTS; k++) begin
            valid_ff[k]   <= (k == 0);
            written_ff[k] <= 1'b0;
         end
      end else begin
         if (wr_en) begin
            written_ff[rd_addr_ff] <= 1'b1;
         end
         if (cmd.op_exec && op_set_valid) begin
            valid_ff[rd_addr_ff] <= 1'b1;
         end
         if (cmd.op_exec && op_clr_valid) begin
            valid_ff[rd_addr_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff      <= TPS_RESET;
         jiffy_ff    <= '0;
         running_ff  <= '0;
         scan_on_ff  <= 1'b0;
         rd_valid_ff <= 1'b0;
         scan_cnt_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            tps_ff <= csr_write_data;
         end
         if (cmd.op_exec && func_ff == FUNC_TICK) begin
            jiffy_ff <= jiffy_ff + 32'd1;
         end
         if (cmd.set_running) begin
            running_ff <= pick_ff;
         end
         rd_valid_ff <= scan_on_ff;
         if (cmd.scan_start) begin
            scan_cnt_ff <= TOP_IDX;
            scan_on_ff  <= 1'b1;
         end else if (scan_on_ff) begin
            scan_cnt_ff <= scan_cnt_ff - IDX_W'(1);
            if (scan_cnt_ff == LAST_IDX) begin
               scan_on_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         func_ff   <= req_func;
         idx_ff    <= req_task_index;
         umode_ff  <= req_user_mode;
         nstate_ff <= req_new_state;
         prio_ff   <= req_priority_value;
         cnt_ff    <= req_counter_value;
         secs_ff   <= req_alarm_seconds;
         incr_ff   <= req_nice_increment;
         sig_ff    <= req_signal_number;
      end
      if (cmd.op_rd) begin
         prod_ff <= 26'(tps_ff) * 26'(secs_ff);
      end
      if (cmd.op_exec) begin
         acc_ff <= op_acc;
         sw_ff  <= op_sched;
      end
      if (cmd.sel_clear) begin
         found_ff <= 1'b0;
         best_ff  <= '0;
         pick_ff  <= '0;
      end else if (sel_take) begin
         found_ff <= 1'b1;
         best_ff  <= row_eff.slice;
         pick_ff  <= rd_addr_ff;
      end
      if (cmd.rsp_load) begin
         rsp_accepted        <= acc_ff;
         rsp_switched        <= sw_ff;
         rsp_current_task    <= 6'(running_ff);
         rsp_current_counter <= row_eff.slice;
      end
   end

   assign sts.need_sched = op_sched;
   assign sts.last_done  = rd_valid_ff && (rd_addr_ff == LAST_IDX);
   assign sts.found      = found_ff;
   assign sts.best_zero  = (best_ff == '0);

`ifndef SYNTHESIS
   a_running_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> valid_ff[running_ff])
      else $error("result names a task that is not installed");
   a_scan_skips_idle: assert property (@(posedge clock) disable iff (reset)
      scan_on_ff |-> (scan_cnt_ff != '0))
      else $error("scan reached the idle task");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> !cmd.op_exec)
      else $error("scan data overlaps an operation");
`endif

endmodule

FILE: verif/counter_priority_task_scheduler_tb.sv
module counter_priority_task_scheduler_tb;
   import cpts_pkg::*;

   typedef struct packed {
      logic [3:0]        func;
      logic [5:0]        idx;
      logic              umode;
      logic [1:0]        nstate;
      logic [7:0]        prio;
      logic [8:0]        cnt;
      logic [15:0]       secs;
      logic signed [8:0] incr;
      logic [5:0]        sig;
   } sched_item_type;

   typedef struct packed {
      logic       acc;
      logic       sw;
      logic [5:0] cur;
      logic [8:0] ctr;
   } sched_result_type;

   typedef struct packed {
      sched_item_type   it;
      logic             typed_in;
      sched_result_type want;
   } dir_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [3:0]        req_func = '0;
   logic [5:0]        req_task_index = '0;
   logic              req_user_mode = 1'b0;
   logic [1:0]        req_new_state = '0;
   logic [7:0]        req_priority_value = '0;
   logic [8:0]        req_counter_value = '0;
   logic [15:0]       req_alarm_seconds = '0;
   logic signed [8:0] req_nice_increment = '0;
   logic [5:0]        req_signal_number = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_accepted;
   logic              rsp_switched;
   logic [5:0]        rsp_current_task;
   logic [8:0]        rsp_current_counter;
   logic              csr_write_enable = 1'b0;
   logic [9:0]        csr_write_data = '0;

   counter_priority_task_scheduler i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_func(req_func), .req_task_index(req_task_index),
      .req_user_mode(req_user_mode), .req_new_state(req_new_state),
      .req_priority_value(req_priority_value), .req_counter_value(req_counter_value),
      .req_alarm_seconds(req_alarm_seconds), .req_nice_increment(req_nice_increment),
      .req_signal_number(req_signal_number),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_accepted(rsp_accepted), .rsp_switched(rsp_switched),
      .rsp_current_task(rsp_current_task), .rsp_current_counter(rsp_current_counter),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always #2 clock = ~clock;

   // Scheduler state as the block should hold it.
   bit         t_valid [64];
   bit [1:0]   t_state [64];
   bit [8:0]   t_slice [64];
   bit [7:0]   t_prio [64];
   bit [31:0]  t_alarm [64];
   bit [31:0]  t_pend [64];
   bit [31:0]  jiffies;
   bit [5:0]   running;
   bit [9:0]   tps;

   sched_result_type pending_results [$];
   int errors = 0;
   bit calm = 1'b0;

   function automatic void sched_clear_slot(int k);
      t_valid[k] = 0;
      t_state[k] = RUN_RUNNING;
      t_slice[k] = 0;
      t_prio[k] = 0;
      t_alarm[k] = 0;
      t_pend[k] = 0;
   endfunction

   function automatic void sched_reset();
      for (int k = 0; k < 64; k++) sched_clear_slot(k);
      t_valid[0] = 1;
      t_slice[0] = IDLE_SLICE;
      t_prio[0] = IDLE_PRIO;
      jiffies = 0;
      running = 0;
      tps = TPS_RESET;
   endfunction

   function automatic void sched_pick();
      bit        found;
      bit [8:0]  best;
      bit [5:0]  pick;
      bit [9:0]  sum;
      for (int k = 63; k >= 1; k--) begin
         if (!t_valid[k]) continue;
         if (t_alarm[k] != 0 && t_alarm[k] < jiffies) begin
            t_pend[k] |= ALARM_BIT;
            t_alarm[k] = 0;
         end
         if (t_pend[k] != 0 && t_state[k] == RUN_INTR) t_state[k] = RUN_RUNNING;
      end
      for (int pass = 0; pass < 2; pass++) begin
         found = 0;
         best = 0;
         pick = 0;
         for (int k = 63; k >= 1; k--) begin
            if (t_valid[k] && t_state[k] == RUN_RUNNING && (!found || t_slice[k] > best)) begin
               found = 1;
               best = t_slice[k];
               pick = 6'(k);
            end
         end
         if (!found || best != 0) break;
         // Every runnable slice is spent, so all installed tasks but the idle one are recharged.
         for (int k = 63; k >= 1; k--) begin
            if (t_valid[k]) begin
               sum = {1'b0, t_slice[k] >> 1} + t_prio[k];
               t_slice[k] = sum > 10'd511 ? 9'd511 : sum[8:0];
            end
         end
      end
      running = pick;
   endfunction

   function automatic sched_result_type sched_apply(sched_item_type it);
      sched_result_type r;
      int               np;
      r = '0;
      case (it.func)
         FUNC_TICK: begin
            r.acc = 1;
            jiffies++;
            if (t_slice[running] > 1) t_slice[running]--;
            else begin
               t_slice[running] = 0;
               if (it.umode) begin
                  sched_pick();
                  r.sw = 1;
               end
            end
         end
         FUNC_SCHEDULE: begin
            r.acc = 1;
            sched_pick();
            r.sw = 1;
         end
         FUNC_INSTALL:
            if (it.idx != 0 && !t_valid[it.idx] && it.prio != 0) begin
               sched_clear_slot(it.idx);
               t_valid[it.idx] = 1;
               t_slice[it.idx] = it.cnt;
               t_prio[it.idx] = it.prio;
               r.acc = 1;
            end
         FUNC_REMOVE:
            if (it.idx != 0 && t_valid[it.idx]) begin
               sched_clear_slot(it.idx);
               r.acc = 1;
               if (it.idx == running) begin
                  sched_pick();
                  r.sw = 1;
               end
            end
         FUNC_SET_STATE:
            if (it.idx != 0 && t_valid[it.idx] && it.nstate != 2'd3) begin
               t_state[it.idx] = it.nstate;
               r.acc = 1;
               if (it.idx == running && it.nstate != RUN_RUNNING) begin
                  sched_pick();
                  r.sw = 1;
               end
            end
         FUNC_ALARM: begin
            r.acc = 1;
            t_alarm[running] = it.secs != 0 ? jiffies + 32'(tps) * 32'(it.secs) : 32'd0;
         end
         FUNC_NICE: begin
            np = int'(t_prio[running]) - int'(it.incr);
            if (np > 0) begin
               t_prio[running] = np > 255 ? PRIO_MAX : np[7:0];
               r.acc = 1;
            end
         end
         FUNC_POST:
            if (t_valid[it.idx] && it.sig >= 1 && it.sig <= 32) begin
               t_pend[it.idx] |= 32'd1 << (it.sig - 1);
               r.acc = 1;
            end
         FUNC_CLEAR:
            if (t_valid[it.idx]) begin
               t_pend[it.idx] = 0;
               r.acc = 1;
            end
         default: ;
      endcase
      r.cur = running;
      r.ctr = t_slice[running];
      return r;
   endfunction

   // Presents one item and holds it until the block takes it; returns at a falling edge.
   task automatic send_item(sched_item_type it, bit typed_in, sched_result_type want);
      sched_result_type r;
      if (!calm && $urandom_range(0, 99) < 9) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_func = it.func;
      req_task_index = it.idx;
      req_user_mode = it.umode;
      req_new_state = it.nstate;
      req_priority_value = it.prio;
      req_counter_value = it.cnt;
      req_alarm_seconds = it.secs;
      req_nice_increment = it.incr;
      req_signal_number = it.sig;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      r = sched_apply(it);
      pending_results.push_back(typed_in ? want : r);
      @(negedge clock);
   endtask

   task automatic drain_and_write_tps(bit [9:0] value);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      csr_write_data = value;
      csr_write_enable = 1'b1;
      @(negedge clock);
      csr_write_enable = 1'b0;
      tps = value;
   endtask

   function automatic sched_item_type random_item();
      sched_item_type it;
      int             pick;
      it.umode = $urandom_range(0, 99) < 80;
      it.nstate = 2'($urandom_range(0, 3));
      it.prio = 8'($urandom_range(0, 255));
      it.cnt = 9'($urandom_range(0, 99) < 70 ? $urandom_range(0, 40) : $urandom_range(0, 511));
      it.secs = 16'($urandom_range(0, 99) < 80 ? $urandom_range(0, 3)
                                                : $urandom_range(0, 65535));
      it.incr = 9'($urandom_range(0, 511));
      it.sig = 6'($urandom_range(0, 99) < 80 ? $urandom_range(1, 32) : $urandom_range(0, 63));
      it.idx = 6'($urandom_range(0, 99) < 80 ? $urandom_range(1, 7) : $urandom_range(0, 63));
      pick = $urandom_range(0, 99);
      if (pick < 35) it.func = FUNC_TICK;
      else if (pick < 45) it.func = FUNC_SCHEDULE;
      else if (pick < 55) it.func = FUNC_INSTALL;
      else if (pick < 60) it.func = FUNC_REMOVE;
      else if (pick < 70) it.func = FUNC_SET_STATE;
      else if (pick < 76) it.func = FUNC_ALARM;
      else if (pick < 82) it.func = FUNC_NICE;
      else if (pick < 90) it.func = FUNC_POST;
      else if (pick < 94) it.func = FUNC_CLEAR;
      else it.func = 4'($urandom_range(0, 15));
      return it;
   endfunction

   localparam sched_result_type IDLE14 = '{1'b0, 1'b0, 6'd0, 9'd14};
   localparam sched_result_type OK14   = '{1'b1, 1'b0, 6'd0, 9'd14};
   localparam sched_result_type NONE   = '0;

   dir_row_type dir_rows [] = '{
      '{'{FUNC_TICK, 6'd0, 1'b0, RUN_RUNNING, 8'd0, 9'd0, 16'd0, 9'sd0, 6'd0}, 1'b1, OK14},
      '{'{FUNC_SCHEDULE, 6'd0, 1'b0, RUN_RUNNING, 8'd0, 9'd0, 16'd0, 9'sd0, 6'd0}, 1'b1,
        '{1'b1, 1'b1, 6'd0, 9'd14}},
      '{'{4'd15, 6'd63, 1'b1, 2'd3, 8'd255, 9'd511, 16'hFFFF, -9'sd256, 6'd63}, 1'b1, IDLE14},
      '{'{FUNC_INSTALL, 6'd0, 1'b0, RUN_RUNNING, 8'd9, 9'd5, 16'd0, 9'sd0, 6'd0}, 1'b1, IDLE14},
      '{'{FUNC_INSTALL, 6'd5, 1'b0, RUN_RUNNING, 8'd0, 9'd5, 16'd0, 9'sd0, 6'd0}, 1'b1, IDLE14},
      '{'{FUNC_INSTALL, 6'd63, 1'b0, RUN_RUNNING, 8'd255, 9'd511, 16'd0, 9'sd0, 6'd0}, 1'b1, OK14},
      '{'{FUNC_INSTALL, 6'd63, 1'b0, RUN_RUNNING, 8'd7, 9'd3, 16'd0, 9'sd0, 6'd0}, 1'b1, IDLE14},
      '{'{FUNC_NICE, 6'd0, 1'b0, RUN_RUNNING, 8'd0, 9'd0, 16'd0, -9'sd255, 6'd0}, 1'b1, OK14},
      '{'{FUNC_NICE, 6'd0, 1'b0, RUN_RUNNING, 8'd0, 9'd0, 16'd0, 9'sd255, 6'd0}, 1'b1, IDLE14},
      '{'{FUNC_SET_STATE, 6'd63, 1'b0, 2'd3, 8'd0, 9'd0, 16'd0, 9'sd0, 6'd0}, 1'b1, IDLE14},
      '{'{FUNC_POST, 6'd63, 1'b0, RUN_RUNNING, 8'd0, 9'd0, 16'd0, 9'sd0, 6'd0}, 1'b1, IDLE14},
      '{'{FUNC_POST, 6'd63, 1'b0, RUN_RUNNING, 8'd0, 9'd0, 16'd0, 9'sd0, 6'd33}, 1'b1, IDLE14},
      '{'{FUNC_POST, 6'd63, 1'b0, RUN_RUNNING, 8'd0, 9'd0, 16'd0, 9'sd0, 6'd32}, 1'b1, OK14},
      '{'{FUNC_SCHEDULE, 6'd0, 1'b0, RUN_RUNNING, 8'd0, 9'd0, 16'd0, 9'sd0, 6'd0}, 1'b1,
        '{1'b1, 1'b1, 6'd63, 9'd511}},
      '{'{FUNC_TICK, 6'd0, 1'b1, RUN_RUNNING, 8'd0, 9'd0, 16'd0, 9'sd0, 6'd0}, 1'b1,
        '{1'b1, 1'b0, 6'd63, 9'd510}},
      '{'{FUNC_INSTALL, 6'd1, 1'b0, RUN_RUNNING, 8'd1, 9'd0, 16'd0, 9'sd0, 6'd0}, 1'b0, NONE},
      '{'{FUNC_SET_STATE, 6'd63, 1'b0, RUN_INTR, 8'd0, 9'd0, 16'd0, 9'sd0, 6'd0}, 1'b0, NONE},
      '{'{FUNC_CLEAR, 6'd63, 1'b0, RUN_RUNNING, 8'd0, 9'd0, 16'd0, 9'sd0, 6'd0}, 1'b0, NONE},
      '{'{FUNC_SET_STATE, 6'd63, 1'b0, RUN_INTR, 8'd0, 9'd0, 16'd0, 9'sd0, 6'd0}, 1'b0, NONE},
      '{'{FUNC_ALARM, 6'd0, 1'b0, RUN_RUNNING, 8'd0, 9'd0, 16'd65535, 9'sd0, 6'd0}, 1'b0, NONE},
      '{'{FUNC_ALARM, 6'd0, 1'b0, RUN_RUNNING, 8'd0, 9'd0, 16'd0, 9'sd0, 6'd0}, 1'b0, NONE},
      '{'{FUNC_TICK, 6'd0, 1'b1, RUN_RUNNING, 8'd0, 9'd0, 16'd0, 9'sd0, 6'd0}, 1'b0, NONE},
      '{'{FUNC_REMOVE, 6'd1, 1'b0, RUN_RUNNING, 8'd0, 9'd0, 16'd0, 9'sd0, 6'd0}, 1'b0, NONE},
      '{'{FUNC_REMOVE, 6'd0, 1'b0, RUN_RUNNING, 8'd0, 9'd0, 16'd0, 9'sd0, 6'd0}, 1'b0, NONE},
      '{'{FUNC_SET_STATE, 6'd63, 1'b0, RUN_UNINTR, 8'd0, 9'd0, 16'd0, 9'sd0, 6'd0}, 1'b0, NONE}
   };

   always @(negedge clock) begin
      rsp_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 9);
   end

   always @(posedge clock) begin
      sched_result_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_accepted, rsp_switched, rsp_current_task, rsp_current_counter};
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   initial begin
      sched_reset();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed_in, dir_rows[i].want);
      // Alarm settings under several tick rates, from 1 up to 1000.
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: drain_and_write_tps(10'd1);
            1: drain_and_write_tps(10'd1000);
            2: drain_and_write_tps(10'd100);
            default: drain_and_write_tps(10'd537);
         endcase
         calm = (p == 2);
         repeat (170) send_item(random_item(), 1'b0, NONE);
      end
      req_valid = 1'b0;
      calm = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (errors == 0 && pending_results.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #20000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
